// ===== hw/rtl/ssmix_pkg.sv =====
// Shared widths and arithmetic for the soft-sum channel mixer.
// Holds the soft-sum merge for both sign cases and the output scale step.
// No dependencies.
package ssmix_pkg;

	localparam int SAMPLE_W = 16;
	localparam int USER_W   = 2;
	localparam int MAG_W    = SAMPLE_W + 1;
	localparam int Q_SHIFT  = SAMPLE_W - 1;

	localparam int USER_PRESENT = 0;
	localparam int USER_FIRST   = 1;

	localparam logic signed [SAMPLE_W-1:0] POS_MAX = 16'sd32767;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// Merge one sample into the running mix.
	// Opposite signs add; same signs use a+b-ab on magnitudes, sign restored.
	function automatic sample_t mix_merge(input sample_t acc, input sample_t s);
		logic                  opposite;
		logic                  neg;
		logic [MAG_W-1:0]      m1;
		logic [MAG_W-1:0]      m2;
		logic [2*MAG_W-1:0]    prod;
		logic [MAG_W:0]        r;
		sample_t               res;
		opposite = (acc < 0 && s >= 0) || (acc > 0 && s <= 0);
		neg      = (acc < 0) || (s < 0);
		m1 = neg ? MAG_W'(-$signed(MAG_W'(acc))) : MAG_W'($signed(acc));
		m2 = neg ? MAG_W'(-$signed(MAG_W'(s)))   : MAG_W'($signed(s));
		prod = m1 * m2;
		// magnitude result never exceeds 1.0
		r = {1'b0, m1} + {1'b0, m2} - prod[Q_SHIFT+MAG_W:Q_SHIFT];
		if (opposite) begin
			res = acc + s;
		end else if (neg) begin
			res = sample_t'(-r[SAMPLE_W-1:0]);
		end else if (r[SAMPLE_W-1]) begin
			res = POS_MAX;
		end else begin
			res = sample_t'(r[SAMPLE_W-1:0]);
		end
		return res;
	endfunction

	// Scale by 32767/32768 with round to nearest: (acc*32767 + 2^14) >>> 15.
	function automatic sample_t mix_scale(input sample_t acc);
		logic signed [2*SAMPLE_W-1:0] w;
		w = $signed({acc[SAMPLE_W-1], acc, {Q_SHIFT{1'b0}}})
			- (2*SAMPLE_W)'(acc)
			+ (2*SAMPLE_W)'(1 << (Q_SHIFT - 1));
		return sample_t'(w[Q_SHIFT+SAMPLE_W-1:Q_SHIFT]);
	endfunction

endpackage

// ===== hw/rtl/soft_sum_audio_channel_mixer_core.sv =====
// Soft-sum audio channel mixer, top level.
// Input register, combinational merge into the frame accumulator, output register.
// Depends on ssmix_pkg.

// Mixes the channel samples of one output frame into a single Q1.15 sample.
// Each item on the input stream carries one channel sample; tuser marks it as
// present (silent channels act as zero) and as the first of a frame, and
// tlast marks the frame's final channel, on which one mixed sample is sent.
// Within a frame, samples of opposite sign add, samples of the same sign
// combine as a+b-ab on their magnitudes (saturating at +32767), and the frame
// result is scaled by 32767/32768 with rounding, so it lies in -32767..32766.
// The accumulator clears after every emitted sample, so a frame also starts
// clean when its first item lacks the first mark. Throughput is one item per
// clock unless the input is stalled: an item sits in the input register while
// the 17x17 merge multiplier updates the accumulator. The result of a last
// item is loaded into the output register at the same edge that moves the
// item out of the input register, so it is valid on the output as soon as
// the item leaves. Input backpressure only occurs when a last item waits for a
// full output register.
module soft_sum_audio_channel_mixer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ssmix_pkg::SAMPLE_W-1:0]  s_tdata,   // [15:0] sample
	input  logic [ssmix_pkg::USER_W-1:0]    s_tuser,   // [0] present, [1] first_channel
	input  logic                            s_tlast,   // last_channel
	// output stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ssmix_pkg::SAMPLE_W-1:0]  m_tdata    // [15:0] mixed_sample
);
	import ssmix_pkg::*;

	// input register
	logic    valid_s1;
	sample_t sample_s1;
	logic    present_s1;
	logic    first_s1;
	logic    last_s1;

	// running mix and output register
	sample_t acc_q;
	logic    out_valid_q;
	sample_t out_data_q;

	sample_t acc_base;
	sample_t acc_next;
	logic    stall;
	logic    advance;

	// a last item may only leave when the output register can take its result
	assign stall    = valid_s1 && last_s1 && out_valid_q && !m_tready;
	assign advance  = valid_s1 && !stall;
	assign s_tready = !stall;

	// first mark clears before merging; a silent channel leaves the mix as is
	assign acc_base = first_s1 ? '0 : acc_q;
	assign acc_next = present_s1 ? mix_merge(acc_base, sample_s1) : acc_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1  <= sample_t'(s_tdata);
			present_s1 <= s_tuser[USER_PRESENT];
			first_s1   <= s_tuser[USER_FIRST];
			last_s1    <= s_tlast;
		end
	end

	// accumulator returns to zero after each frame result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (advance) begin
			acc_q <= last_s1 ? '0 : acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_data_q <= mix_scale(acc_next);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// backpressure only comes from a full, stalled output register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without a blocked result");

	// a new result only follows a last item leaving the input register
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s1 && last_s1))
		else $error("result without a last item");

	// mix restarts from zero after each frame
	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (acc_q == '0))
		else $error("accumulator not cleared at end of frame");

	// scaled output never reaches the most negative code
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata != {1'b1, {(SAMPLE_W-1){1'b0}}}))
		else $error("mixed sample out of range");

endmodule

// ===== bench/ssmix_check_pkg.sv =====
// Scoreboard for the soft-sum channel mixer: item type, mix predictor, result check.
// Depends on ssmix_pkg for the sample type only.
package ssmix_check_pkg;

	import ssmix_pkg::sample_t;

	localparam int MIX_SHIFT   = 15;
	localparam int MIX_POS_MAX = 32767;
	localparam int MIX_NEG_MIN = -32768;
	localparam int OUT_SCALE   = 32767;
	localparam int OUT_ROUND   = 16384;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		sample_t sample;
		bit      present;
		bit      first;
		bit      last;
	} chan_item_t;

	// One merge step: opposite signs add, same signs give a+b-ab on magnitudes.
	function automatic sample_t soft_sum(input sample_t acc, input sample_t s);
		int a;
		int b;
		int m1;
		int m2;
		int r;
		bit neg;
		a = acc;
		b = s;
		if ((a < 0 && b >= 0) || (a > 0 && b <= 0)) begin
			return sample_t'(a + b);
		end
		neg = (a < 0) || (b < 0);
		m1  = neg ? -a : a;
		m2  = neg ? -b : b;
		r   = m1 + m2 - ((m1 * m2) >>> MIX_SHIFT);
		if (neg) begin
			r = -r;
		end
		if (r > MIX_POS_MAX) begin
			r = MIX_POS_MAX;
		end
		if (r < MIX_NEG_MIN) begin
			r = MIX_NEG_MIN;
		end
		return sample_t'(r);
	endfunction

	// Scale by 32767/32768, round half up.
	function automatic sample_t scale_to_output(input sample_t acc);
		longint p;
		p = longint'(acc) * OUT_SCALE + OUT_ROUND;
		return sample_t'(p >>> MIX_SHIFT);
	endfunction

	class mix_scoreboard;
		sample_t frame_acc;
		sample_t expected_mix[$];
		int      n_items;
		int      n_checked;
		int      n_errors;

		function new();
			frame_acc = '0;
			n_items   = 0;
			n_checked = 0;
			n_errors  = 0;
		endfunction

		function void note_item(input chan_item_t it);
			n_items++;
			if (it.first) begin
				frame_acc = '0;
			end
			if (it.present) begin
				frame_acc = soft_sum(frame_acc, it.sample);
			end
			if (it.last) begin
				expected_mix.push_back(scale_to_output(frame_acc));
				frame_acc = '0;
			end
		endfunction

		function void check_mix(input sample_t got);
			sample_t want;
			if (expected_mix.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS) begin
					$display("[%0t] unexpected mixed sample %0d", $realtime, got);
				end
				return;
			end
			want = expected_mix.pop_front();
			n_checked++;
			if (got !== want) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS) begin
					$display("[%0t] mixed sample %0d: expected %0d, got %0d",
						$realtime, n_checked, want, got);
				end
			end
		endfunction
	endclass

endpackage

// ===== bench/soft_sum_audio_channel_mixer_core_test.sv =====
// Self-checking bench for soft_sum_audio_channel_mixer_core.
// Directed frames, then random frames with random idling on both streams.
// Depends on ssmix_pkg and ssmix_check_pkg.
module soft_sum_audio_channel_mixer_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	import ssmix_pkg::*;
	import ssmix_check_pkg::*;

	localparam int  RANDOM_ITEMS = 400;
	localparam int  IDLE_PCT     = 6;
	localparam int  CALM_FROM    = 150;   // random items in [CALM_FROM, CALM_TO) never idle
	localparam int  CALM_TO      = 280;
	localparam int  DRAIN_CYCLES = 8;
	localparam time WATCHDOG_NS  = 2_000_000;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [SAMPLE_W-1:0] s_tdata  = '0;    // [15:0] sample
	logic [USER_W-1:0]   s_tuser  = '0;    // [0] present, [1] first_channel
	logic                s_tlast  = 1'b0;  // last_channel
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [SAMPLE_W-1:0] m_tdata;          // [15:0] mixed_sample

	int            idle_pct = IDLE_PCT;
	int            sent     = 0;
	chan_item_t    seen;
	mix_scoreboard sb = new();

	soft_sum_audio_channel_mixer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Output side: random stalls, one decision per falling edge.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= idle_pct);
	end

	// Both handshakes are observed at the rising edge. An input item and a
	// result accepted on the same edge never belong together (the result was loaded
	// after its item left the input register), so noting the input first is safe.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				seen.sample  = sample_t'(s_tdata);
				seen.present = s_tuser[USER_PRESENT];
				seen.first   = s_tuser[USER_FIRST];
				seen.last    = s_tlast;
				sb.note_item(seen);
			end
			if (m_tvalid && m_tready) begin
				sb.check_mix(sample_t'(m_tdata));
			end
		end
	end

	// Present one channel item from a falling edge and hold it until taken.
	// Valid stays high into the next item unless an idle cycle is drawn.
	task automatic send_item(input sample_t smp, input bit pres, input bit frst,
			input bit lst);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid = 1'b0;
			s_tdata  = SAMPLE_W'($urandom);   // junk while idle, must be ignored
			@(negedge clk);
		end
		s_tvalid              = 1'b1;
		s_tdata               = smp;
		s_tuser[USER_PRESENT] = pres;
		s_tuser[USER_FIRST]   = frst;
		s_tlast               = lst;
		do begin
			@(posedge clk);
		end while (!s_tready);
		sent++;
		@(negedge clk);
	endtask

	// Mostly full-range noise, with a share of extremes and near-zero values.
	function automatic sample_t pick_sample();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(4))
					0:       return sample_t'(MIX_POS_MAX);
					1:       return sample_t'(MIX_NEG_MIN);
					2:       return sample_t'(0);
					3:       return sample_t'(1);
					default: return sample_t'(-1);
				endcase
			end
			1:       return sample_t'(int'($urandom_range(64)) - 32);
			default: return sample_t'($urandom);
		endcase
	endfunction

	initial begin
		int  len;
		int  n_random;
		bit  broken;
		bit  pres;
		bit  frst;
		bit  lst;
		int  errors;

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed frames ---
		// frame of one silent channel gives zero
		send_item(16'sh7abc, 1'b0, 1'b1, 1'b1);
		// lone full-scale samples, both marks on one item
		send_item(sample_t'(MIX_POS_MAX), 1'b1, 1'b1, 1'b1);
		send_item(sample_t'(MIX_NEG_MIN), 1'b1, 1'b1, 1'b1);
		// positive same-sign merge saturates
		send_item(sample_t'(MIX_POS_MAX), 1'b1, 1'b1, 1'b0);
		send_item(sample_t'(MIX_POS_MAX), 1'b1, 1'b0, 1'b1);
		// negative full scale is reachable and kept
		send_item(sample_t'(MIX_NEG_MIN), 1'b1, 1'b1, 1'b0);
		send_item(sample_t'(MIX_NEG_MIN), 1'b1, 1'b0, 1'b1);
		// opposite signs simply add
		send_item(16'sd20000, 1'b1, 1'b1, 1'b0);
		send_item(-16'sd5000, 1'b1, 1'b0, 1'b0);
		send_item(sample_t'(MIX_NEG_MIN), 1'b1, 1'b0, 1'b1);
		// zero operands on either side
		send_item(16'sd0, 1'b1, 1'b1, 1'b0);
		send_item(-16'sd1, 1'b1, 1'b0, 1'b0);
		send_item(16'sd0, 1'b1, 1'b0, 1'b0);
		send_item(16'sd1, 1'b1, 1'b0, 1'b1);
		// silent channel in mid-frame
		send_item(16'sd1000, 1'b1, 1'b1, 1'b0);
		send_item(sample_t'(MIX_NEG_MIN), 1'b0, 1'b0, 1'b0);
		send_item(16'sd2000, 1'b1, 1'b0, 1'b1);
		// frame without a first mark still starts clean
		send_item(16'sd3000, 1'b1, 1'b0, 1'b0);
		send_item(16'sd4000, 1'b1, 1'b0, 1'b1);
		// first mark in mid-frame drops what was mixed so far
		send_item(-16'sd9000, 1'b1, 1'b1, 1'b0);
		send_item(16'sd16384, 1'b1, 1'b1, 1'b0);
		send_item(16'sd16384, 1'b1, 1'b0, 1'b1);
		// silent last channel
		send_item(-16'sd1, 1'b1, 1'b1, 1'b0);
		send_item(16'sd12345, 1'b0, 1'b0, 1'b1);

		// --- random frames ---
		// Most frames are well formed (first mark on the opening item, last on
		// the closing one); the rest carry marks at random.
		n_random = 0;
		while (n_random < RANDOM_ITEMS) begin
			len    = ($urandom_range(9) == 0) ? $urandom_range(12, 1) : $urandom_range(6, 1);
			broken = ($urandom_range(99) < 15);
			for (int k = 0; k < len; k++) begin
				idle_pct = (n_random >= CALM_FROM && n_random < CALM_TO) ? 0 : IDLE_PCT;
				pres = ($urandom_range(99) < 80);
				if (broken) begin
					frst = ($urandom_range(3) == 0);
					lst  = ($urandom_range(3) == 0);
				end else begin
					frst = (k == 0);
					lst  = (k == len - 1);
				end
				send_item(pick_sample(), pres, frst, lst);
				n_random++;
			end
		end
		idle_pct = IDLE_PCT;
		s_tvalid = 1'b0;

		// drain: every expected mix must arrive; the watchdog bounds this wait
		while (sb.expected_mix.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		errors = sb.n_errors + sb.expected_mix.size();
		$display("Sent %0d channel items (%0d random), checked %0d mixed samples.",
			sent, n_random, sb.n_checked);
		$display("Errors: %0d (%0d mixes still outstanding).", errors,
			sb.expected_mix.size());
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#(WATCHDOG_NS);
		$display("Timeout after %0t with %0d mixes outstanding.", $realtime,
			sb.expected_mix.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/ssmix_pkg.sv
hw/rtl/soft_sum_audio_channel_mixer_core.sv
bench/ssmix_check_pkg.sv
bench/soft_sum_audio_channel_mixer_core_test.sv
